FILE: sv/tile_region_clip_row_emitter_unit_macros.svh
// Assertion macros shared by the tile region clip row emitter.
`ifndef TILE_REGION_CLIP_ROW_EMITTER_UNIT_MACROS_SVH
`define TILE_REGION_CLIP_ROW_EMITTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on the rising clock, switched off while reset is held.
`define TRCE_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks a property on the rising clock at every edge, reset included.
`define TRCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRCE_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define TRCE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: sv/trce_pkg.sv
// Types and constants of the tile region clip row emitter.
package trce_pkg;

    // Halfwords of header in front of the source pixel data.
    localparam logic [31:0] HEADER_HALFWORDS = 32'd6;

    // Source stride and row count are the pixel sizes divided by eight.
    localparam int STRIDE_W = 13;

    typedef struct packed {
        logic                command;
        logic signed [15:0]  dst_x;
        logic signed [15:0]  dst_y;
        logic [15:0]         src_x;
        logic [15:0]         src_y;
        logic signed [15:0]  req_width;
        logic signed [15:0]  req_height;
        logic [15:0]         source_width_px;
        logic [15:0]         source_height_px;
        logic [2:0]          layer;
    } t_request;

    typedef struct packed {
        logic        row_valid;
        logic        clear_row;
        logic [31:0] src_offset;
        logic [9:0]  dst_offset;
        logic [5:0]  row_length;
        logic [7:0]  dirty_mask;
        logic        last;
    } t_result;

    // Load strobes for the two register stages of an axis clipper.
    typedef struct packed {
        logic load_shift;
        logic load_clip;
    } t_clip_ctrl;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SHIFT = 6'b000010,
        S_CLIP  = 6'b000100,
        S_CHECK = 6'b001000,
        S_BASE  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

endpackage

FILE: sv/trce_axis_clip.sv
// One axis of the region clipper: default size, leading edge shift, trailing edge cut.
module trce_axis_clip #(
    parameter int LIMIT = 32
) (
    input  logic                         i_clk,
    input  trce_pkg::t_clip_ctrl         i_ctrl,
    input  logic signed [15:0]           i_dst,
    input  logic [15:0]                  i_src,
    input  logic signed [15:0]           i_size,
    input  logic [trce_pkg::STRIDE_W-1:0] i_default,
    output logic [15:0]                  o_pos,
    output logic [16:0]                  o_src,
    output logic signed [18:0]           o_len
);

    localparam logic signed [18:0] LIMIT_S = 19'(LIMIT);

    logic [15:0]        r_pos;
    logic [16:0]        r_src;
    logic signed [18:0] r_len;

    logic signed [18:0] n_size;
    logic signed [18:0] n_dst_ext;
    logic [16:0]        n_cut;
    logic signed [18:0] n_pos_s;
    logic signed [18:0] n_end;

    // Size defaults to the source size; a negative start moves the source origin.
    always_comb begin
        n_size    = (i_size == -16'sd1) ? $signed({6'b0, i_default})
                                        : $signed({{3{i_size[15]}}, i_size});
        n_dst_ext = $signed({{3{i_dst[15]}}, i_dst});
        n_cut     = 17'd0 - {i_dst[15], i_dst};
        n_pos_s   = $signed({3'b0, r_pos});
        n_end     = n_pos_s + r_len;
    end

    // First stage takes the leading edge, second stage cuts at the far edge.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_shift) begin
            if (i_dst[15]) begin
                r_pos <= '0;
                r_src <= {1'b0, i_src} + n_cut;
                r_len <= n_size + n_dst_ext;
            end else begin
                r_pos <= i_dst;
                r_src <= {1'b0, i_src};
                r_len <= n_size;
            end
        end else if (i_ctrl.load_clip) begin
            if (n_end > LIMIT_S) begin
                r_len <= LIMIT_S - n_pos_s;
            end
        end
    end

    assign o_pos = r_pos;
    assign o_src = r_src;
    assign o_len = r_len;

endmodule

FILE: sv/tile_region_clip_row_emitter_unit.sv
// Top level of the tile region clip row emitter.
// A request is taken when start is high and busy is low. The region is clipped to
// the SCREEN_COLS by SCREEN_ROWS tile screen and one row descriptor follows per
// remaining row, one per clock cycle, each on o_result for a single cycle marked
// by o_result_valid; the receiver cannot hold results off. A request goes through four
// set-up steps (edge shift, edge cut, empty check with the stride multiply, source
// base add) and then gives one row per cycle, with busy high throughout. The final
// result is on the ports in the cycle after the last row step, when busy is already
// low, so the next request can be taken while it is shown. An empty region drops
// busy after the empty check and gives its one result, with no row, once busy
// is low. Every request sets its layer's bit in the sticky dirty mask, and every
// result carries the mask.
`include "tile_region_clip_row_emitter_unit_macros.svh"
module tile_region_clip_row_emitter_unit #(
    parameter int SCREEN_COLS = 32,
    parameter int SCREEN_ROWS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  trce_pkg::t_request i_request,
    output logic               busy,
    output logic               o_result_valid,
    output trce_pkg::t_result  o_result
);

    localparam int          ROW_W  = $clog2(SCREEN_ROWS + 1);
    localparam logic [9:0]  COLS10 = 10'(SCREEN_COLS);

    trce_pkg::t_state     r_state, n_state;
    trce_pkg::t_request   r_req;
    trce_pkg::t_result    r_result;
    trce_pkg::t_clip_ctrl clip_ctrl;
    logic                 r_result_valid;
    logic [7:0]           r_dirty;
    logic [29:0]          r_prod;
    logic [31:0]          r_src;
    logic [9:0]           r_dst;
    logic [5:0]           r_len;
    logic [ROW_W-1:0]     r_rows;

    logic                 accept;
    logic                 empty;
    logic [trce_pkg::STRIDE_W-1:0] stride;
    logic [trce_pkg::STRIDE_W-1:0] src_rows;
    logic [15:0]          x_pos, y_pos;
    logic [16:0]          x_src, y_src;
    logic signed [18:0]   x_len, y_len;

    assign accept   = start && (r_state == trce_pkg::S_IDLE);
    assign busy     = (r_state != trce_pkg::S_IDLE);
    assign stride   = r_req.source_width_px[15:3];
    assign src_rows = r_req.source_height_px[15:3];

    assign clip_ctrl.load_shift = (r_state == trce_pkg::S_SHIFT);
    assign clip_ctrl.load_clip  = (r_state == trce_pkg::S_CLIP);

    // Column and row clippers run side by side.
    trce_axis_clip #(
        .LIMIT (SCREEN_COLS)
    ) u_clip_x (
        .i_clk     (i_clk),
        .i_ctrl    (clip_ctrl),
        .i_dst     (r_req.dst_x),
        .i_src     (r_req.src_x),
        .i_size    (r_req.req_width),
        .i_default (stride),
        .o_pos     (x_pos),
        .o_src     (x_src),
        .o_len     (x_len)
    );

    trce_axis_clip #(
        .LIMIT (SCREEN_ROWS)
    ) u_clip_y (
        .i_clk     (i_clk),
        .i_ctrl    (clip_ctrl),
        .i_dst     (r_req.dst_y),
        .i_src     (r_req.src_y),
        .i_size    (r_req.req_height),
        .i_default (src_rows),
        .o_pos     (y_pos),
        .o_src     (y_src),
        .o_len     (y_len)
    );

    // A region with no positive width or height yields no rows.
    assign empty = x_len[18] || (x_len == '0) || y_len[18] || (y_len == '0);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            trce_pkg::S_IDLE: begin
                if (start) begin
                    n_state = trce_pkg::S_SHIFT;
                end
            end
            trce_pkg::S_SHIFT: n_state = trce_pkg::S_CLIP;
            trce_pkg::S_CLIP:  n_state = trce_pkg::S_CHECK;
            trce_pkg::S_CHECK: n_state = empty ? trce_pkg::S_IDLE : trce_pkg::S_BASE;
            trce_pkg::S_BASE:  n_state = trce_pkg::S_EMIT;
            trce_pkg::S_EMIT: begin
                if (r_rows == ROW_W'(1)) begin
                    n_state = trce_pkg::S_IDLE;
                end
            end
            default: n_state = trce_pkg::S_IDLE;
        endcase
    end

    // Control registers: state, result strobe and the sticky dirty mask.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= trce_pkg::S_IDLE;
            r_result_valid <= 1'b0;
            r_dirty        <= '0;
        end else begin
            r_state        <= n_state;
            r_result_valid <= ((r_state == trce_pkg::S_CHECK) && empty)
                              || (r_state == trce_pkg::S_EMIT);
            if (accept) begin
                r_dirty <= r_dirty | (8'd1 << i_request.layer);
            end
        end
    end

    // Datapath: one multiply for the first source row, then an add per row.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_request;
        end
        case (r_state)
            trce_pkg::S_CHECK: begin
                r_prod <= 30'(stride) * 30'(y_src);
                r_dst  <= x_pos[9:0] + y_pos[9:0] * COLS10;
                r_len  <= x_len[5:0];
                r_rows <= y_len[ROW_W-1:0];
                r_result.row_valid  <= 1'b0;
                r_result.clear_row  <= 1'b0;
                r_result.src_offset <= '0;
                r_result.dst_offset <= '0;
                r_result.row_length <= '0;
                r_result.dirty_mask <= r_dirty;
                r_result.last       <= 1'b1;
            end
            trce_pkg::S_BASE: begin
                r_src <= 32'(r_prod) + 32'(x_src) + trce_pkg::HEADER_HALFWORDS;
            end
            trce_pkg::S_EMIT: begin
                r_result.row_valid  <= 1'b1;
                r_result.clear_row  <= ~r_req.command;
                r_result.src_offset <= r_src;
                r_result.dst_offset <= r_dst;
                r_result.row_length <= r_len;
                r_result.dirty_mask <= r_dirty;
                r_result.last       <= (r_rows == ROW_W'(1));
                r_src  <= r_src + 32'(stride);
                r_dst  <= r_dst + COLS10;
                r_rows <= r_rows - ROW_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

    // Checks on the sequencer and the result stream.
    `TRCE_ASSERT_RST(a_accept_busy, i_clk, i_rst_n, start && !busy |=> busy, "accepted transaction did not raise busy")
    `TRCE_ASSERT_RST(a_last_frees, i_clk, i_rst_n, o_result_valid && o_result.last |-> !busy, "busy still high with the final result")
    `TRCE_ASSERT_RST(a_mid_busy, i_clk, i_rst_n, o_result_valid && !o_result.last |-> busy, "more results due but block is idle")
    `TRCE_ASSERT_RST(a_empty_last, i_clk, i_rst_n, o_result_valid && !o_result.row_valid |-> o_result.last, "result without a row is not final")
    `TRCE_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_result_valid, "result strobe after reset")

endmodule
